[rtl/bdlr_pkg.sv]
// ----------------------------------------------------------------------------
// bdlr_pkg
// Shared types and constants for the multiplexed button debouncer with
// long-press and auto-repeat events.
// ----------------------------------------------------------------------------
package bdlr_pkg;

    localparam int NUM_BUTTONS_DEF = 6;

    localparam int CMD_W    = 2;
    localparam int BTN_W    = 3;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int EV_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL        = 2'd0,
        CMD_RESET_TRACK = 2'd1,
        CMD_STAMP       = 2'd2
    } cmd_t;

    typedef enum logic [EV_W-1:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_LONG    = 3'd3,
        EV_REPEAT  = 3'd4
    } ev_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_LONG_PRESS   = 3'd1,
        REG_REPEAT_DELAY = 3'd2,
        REG_REPEAT_PERIOD = 3'd3,
        REG_LONG_BUTTON  = 3'd4
    } cfg_reg_t;

    localparam logic [MS_W-1:0]  DEBOUNCE_RST      = 16'd20;
    localparam logic [MS_W-1:0]  LONG_PRESS_RST    = 16'd1000;
    localparam logic [MS_W-1:0]  REPEAT_DELAY_RST  = 16'd500;
    localparam logic [MS_W-1:0]  REPEAT_PERIOD_RST = 16'd100;
    localparam logic [BTN_W-1:0] LONG_BUTTON_RST   = 3'd5;

    typedef struct packed {
        logic [MS_W-1:0]  debounce_ms;
        logic [MS_W-1:0]  long_press_ms;
        logic [MS_W-1:0]  repeat_delay_ms;
        logic [MS_W-1:0]  repeat_period_ms;
        logic [BTN_W-1:0] long_press_button;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BTN_W-1:0]  button;
        logic              raw_pressed;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic              is_pressed;
        logic              any_pressed;
        logic [TIME_W-1:0] last_activity;
    } result_t;

    // Per-button tracking entry
    typedef struct packed {
        logic              prev_raw;
        logic              debounced;
        logic [TIME_W-1:0] change_time;
        logic [TIME_W-1:0] press_start;
        logic              long_marked;
        logic              repeat_active;
        logic [TIME_W-1:0] repeat_time;
    } entry_t;

endpackage

[rtl/bdlr_cfg.sv]
// ----------------------------------------------------------------------------
// bdlr_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bdlr_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [bdlr_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [bdlr_pkg::CFG_DATA_W-1:0]    wr_data,
    output bdlr_pkg::cfg_t                     cfg
);

    bdlr_pkg::cfg_t cfg_reg;
    bdlr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (bdlr_pkg::cfg_reg_t'(wr_index))
                bdlr_pkg::REG_DEBOUNCE:      cfg_next.debounce_ms      = wr_data;
                bdlr_pkg::REG_LONG_PRESS:    cfg_next.long_press_ms    = wr_data;
                bdlr_pkg::REG_REPEAT_DELAY:  cfg_next.repeat_delay_ms  = wr_data;
                bdlr_pkg::REG_REPEAT_PERIOD: cfg_next.repeat_period_ms = wr_data;
                bdlr_pkg::REG_LONG_BUTTON:
                    cfg_next.long_press_button = wr_data[bdlr_pkg::BTN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms       <= bdlr_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ms     <= bdlr_pkg::LONG_PRESS_RST;
            cfg_reg.repeat_delay_ms   <= bdlr_pkg::REPEAT_DELAY_RST;
            cfg_reg.repeat_period_ms  <= bdlr_pkg::REPEAT_PERIOD_RST;
            cfg_reg.long_press_button <= bdlr_pkg::LONG_BUTTON_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/bdlr_engine.sv]
// ----------------------------------------------------------------------------
// bdlr_engine
// Per-button tracking state and the single-pass step logic for one item.
// ----------------------------------------------------------------------------
module bdlr_engine #(
    parameter int NUM_BUTTONS = bdlr_pkg::NUM_BUTTONS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_go,
    input  bdlr_pkg::item_t    item,
    input  bdlr_pkg::cfg_t     cfg,
    output bdlr_pkg::result_t  result
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    bdlr_pkg::entry_t                  btn_reg [NUM_BUTTONS];
    logic [bdlr_pkg::TIME_W-1:0]       activity_reg;
    logic [bdlr_pkg::TIME_W-1:0]       activity_next;

    logic                              sel_valid;
    logic [IDX_W-1:0]                  sel;
    bdlr_pkg::cmd_t                    cmd;
    bdlr_pkg::entry_t                  cur;
    bdlr_pkg::entry_t                  upd;
    logic                              wr;
    logic                              long_ev;
    bdlr_pkg::ev_t                     ev;
    logic [bdlr_pkg::TIME_W-1:0]       now;
    logic [bdlr_pkg::TIME_W-1:0]       ct_new;
    logic [bdlr_pkg::TIME_W-1:0]       d_change;
    logic [bdlr_pkg::TIME_W-1:0]       d_press;
    logic [bdlr_pkg::TIME_W-1:0]       d_repeat;
    logic [NUM_BUTTONS-1:0]            deb_next;

    assign cmd       = bdlr_pkg::cmd_t'(item.command);
    assign now       = item.now_ms;
    assign sel_valid = (32'(item.button) < NUM_BUTTONS);
    assign sel       = IDX_W'(item.button);
    assign cur       = sel_valid ? btn_reg[sel] : '0;
    assign ct_new    = (item.raw_pressed != cur.prev_raw) ? now : cur.change_time;
    assign d_change  = now - ct_new;
    assign d_press   = now - cur.press_start;
    assign d_repeat  = now - cur.repeat_time;

    always_comb
    begin
        upd           = cur;
        wr            = 1'b0;
        long_ev       = 1'b0;
        ev            = bdlr_pkg::EV_NONE;
        activity_next = activity_reg;
        case (cmd)
            bdlr_pkg::CMD_POLL:
            begin
                if (sel_valid)
                begin
                    wr              = 1'b1;
                    upd.prev_raw    = item.raw_pressed;
                    upd.change_time = ct_new;
                    if (d_change < 32'(cfg.debounce_ms))
                    begin
                        ev = bdlr_pkg::EV_NONE;   // still bouncing
                    end
                    else if (item.raw_pressed != cur.debounced)
                    begin
                        upd.debounced     = item.raw_pressed;
                        upd.repeat_active = 1'b0;
                        if (item.raw_pressed)
                        begin
                            upd.press_start = now;
                            upd.long_marked = 1'b0;
                            activity_next   = now;
                            ev              = bdlr_pkg::EV_PRESS;
                        end
                        else
                        begin
                            upd.press_start = '0;
                            ev              = bdlr_pkg::EV_RELEASE;
                        end
                    end
                    else if (cur.debounced)
                    begin
                        if (!cur.long_marked && d_press >= 32'(cfg.long_press_ms))
                        begin
                            upd.long_marked = 1'b1;
                            if (item.button == cfg.long_press_button)
                            begin
                                activity_next = now;
                                ev            = bdlr_pkg::EV_LONG;
                                long_ev       = 1'b1;
                            end
                        end
                        // other buttons fall through to the repeat checks
                        if (!long_ev)
                        begin
                            if (!cur.repeat_active)
                            begin
                                if (d_press >= 32'(cfg.repeat_delay_ms))
                                begin
                                    upd.repeat_active = 1'b1;
                                    upd.repeat_time   = now;
                                    activity_next     = now;
                                    ev                = bdlr_pkg::EV_REPEAT;
                                end
                            end
                            else if (d_repeat >= 32'(cfg.repeat_period_ms))
                            begin
                                upd.repeat_time = now;
                                activity_next   = now;
                                ev              = bdlr_pkg::EV_REPEAT;
                            end
                        end
                    end
                end
            end
            bdlr_pkg::CMD_STAMP:
            begin
                activity_next = now;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            deb_next[i] = (wr && (sel == IDX_W'(i))) ? upd.debounced
                                                     : btn_reg[i].debounced;
        end
    end

    assign result.event_res     = ev;
    assign result.is_pressed    = sel_valid && upd.debounced;
    assign result.any_pressed   = |deb_next;
    assign result.last_activity = activity_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                btn_reg[i] <= '0;
            end
            activity_reg <= '0;
        end
        else if (step_go)
        begin
            activity_reg <= activity_next;
            if (cmd == bdlr_pkg::CMD_RESET_TRACK)
            begin
                for (int i = 0; i < NUM_BUTTONS; i++)
                begin
                    btn_reg[i].press_start   <= '0;
                    btn_reg[i].long_marked   <= 1'b0;
                    btn_reg[i].repeat_active <= 1'b0;
                end
            end
            else if (wr)
            begin
                btn_reg[sel] <= upd;
            end
        end
    end

endmodule

[rtl/button_debounce_longpress_repeat_top.sv]
// ----------------------------------------------------------------------------
// button_debounce_longpress_repeat_top
// Multiplexed button debouncer reporting press, release, long press and
// auto-repeat events, one command item in and one result item out.
// ----------------------------------------------------------------------------
// Result path: each item passes the input register, then the result register,
//   and waits in the input register while the result slot is stalled.
// Throughput: one item per cycle when the result side does not stall; state
//   read-modify-write per button completes in the step, so back-to-back polls see fresh state.
// Reset: all buttons released, all times zero, registers at their defaults.
// ----------------------------------------------------------------------------
module button_debounce_longpress_repeat_top #(
    parameter int NUM_BUTTONS = bdlr_pkg::NUM_BUTTONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bdlr_pkg::CMD_W-1:0]        command,
    input  logic [bdlr_pkg::BTN_W-1:0]        button,
    input  logic                              raw_pressed,
    input  logic [bdlr_pkg::TIME_W-1:0]       now_ms,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bdlr_pkg::EV_W-1:0]         event_res,
    output logic                              is_pressed,
    output logic                              any_pressed,
    output logic [bdlr_pkg::TIME_W-1:0]       last_activity,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bdlr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bdlr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    bdlr_pkg::cfg_t     cfg;
    bdlr_pkg::item_t    item_reg;
    bdlr_pkg::result_t  res_reg;
    bdlr_pkg::result_t  res_next;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               step_go;

    // Config writes are always taken; the register file only changes on
    // known indexes.
    assign cfg_ready = 1'b1;

    bdlr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The item in the input register moves to the result register whenever
    // the result slot is empty or being drained this cycle. State updates
    // happen at that same edge, so the next item always sees them.
    assign advance  = !out_valid_reg || out_ready;
    assign step_go  = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.command     <= command;
            item_reg.button      <= button;
            item_reg.raw_pressed <= raw_pressed;
            item_reg.now_ms      <= now_ms;
        end
    end

    bdlr_engine #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_go (step_go),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = res_reg.event_res;
    assign is_pressed    = res_reg.is_pressed;
    assign any_pressed   = res_reg.any_pressed;
    assign last_activity = res_reg.last_activity;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An empty result slot never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled while result slot empty");

    // Press, long press and repeat only come from a pressed button.
    a_press_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == bdlr_pkg::EV_PRESS ||
                       event_res == bdlr_pkg::EV_LONG ||
                       event_res == bdlr_pkg::EV_REPEAT))
        |-> (is_pressed && any_pressed))
        else $error("press-type event on a released button");

    // A release leaves the addressed button released.
    a_release_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == bdlr_pkg::EV_RELEASE) |-> !is_pressed)
        else $error("release event with button still pressed");

    // Activity time follows now_ms on a press.
    a_press_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && (res_next.event_res == bdlr_pkg::EV_PRESS)
        |-> (res_next.last_activity == item_reg.now_ms))
        else $error("press did not stamp activity time");

endmodule
